/* rtl/tcq_pkg.sv */
package tcq_pkg;

	typedef enum logic [1:0] {
		OP_RESERVE = 2'd0,
		OP_PUSH    = 2'd1,
		OP_PLAN    = 2'd2,
		OP_RETIRE  = 2'd3
	} op_t;

	localparam logic [1:0] KIND_DROP   = 2'd0;
	localparam logic [1:0] KIND_PLAN   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NO_SPACE    = 2'd1;
	localparam logic [1:0] ST_BAD_CLASS   = 2'd2;
	localparam logic [1:0] ST_RETIRE_OVER = 2'd3;

	localparam logic [1:0] CLASS_INVALID = 2'd3;

	localparam logic CFG_BATCH_CAPACITY = 1'b0;
	localparam logic CFG_QUEUE_LIMIT    = 1'b1;

	localparam logic [5:0] BATCH_CAPACITY_RESET = 6'd32;
	localparam logic [8:0] QUEUE_LIMIT_RESET    = 9'd160;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       latch;
		logic       set_st;
		logic [1:0] st_code;
		logic       push;
		logic       retire;
		logic       rd_first;
		logic       rd_second;
		logic       adv_one;
		logic       adv_two;
		logic       plan_init;
		logic       plan_start;
		logic       plan_rd;
		logic       plan_step;
		logic       plan_next;
		logic       emit_handle;
		logic       plan_sel;
		logic       emit_status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic bad_class;
		logic oversize;
		logic push_full;
		logic retire_over;
		logic drop_needed;
		logic first_grp;
		logic two_held;
		logic second_last;
		logic plan_more;
		logic plan_pending;
		logic out_free;
	} sts_t;

endpackage

/* rtl/tcq_ifs.sv */
interface tcq_req_if #(
	parameter int HANDLE_WIDTH = 16
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              opcode;
	logic [1:0]              traffic_class;
	logic [HANDLE_WIDTH-1:0] packet_handle;
	logic                    starts_group;
	logic                    ends_group;
	logic [5:0]              entry_count;

	modport source (output valid, opcode, traffic_class, packet_handle, starts_group,
		ends_group, entry_count, input ready);
	modport sink (input valid, opcode, traffic_class, packet_handle, starts_group,
		ends_group, entry_count, output ready);
endinterface

interface tcq_rsp_if #(
	parameter int HANDLE_WIDTH = 16
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              result_kind;
	logic [1:0]              result_class;
	logic [HANDLE_WIDTH-1:0] result_handle;
	logic [1:0]              status_code;
	logic [5:0]              realtime_planned;
	logic [5:0]              video_planned;
	logic [5:0]              data_planned;
	logic                    last_result;

	modport source (output valid, result_kind, result_class, result_handle, status_code,
		realtime_planned, video_planned, data_planned, last_result, input ready);
	modport sink (input valid, result_kind, result_class, result_handle, status_code,
		realtime_planned, video_planned, data_planned, last_result, output ready);
endinterface

/* rtl/tcq_ram.sv */
module tcq_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

/* rtl/tcq_ctrl.sv */
module tcq_ctrl import tcq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_DECIDE  = 9'b000000010,
		S_RLOOP   = 9'b000000100,
		S_RFIRST  = 9'b000001000,
		S_RSECOND = 9'b000010000,
		S_PCLASS  = 9'b000100000,
		S_PREAD   = 9'b001000000,
		S_PEMIT   = 9'b010000000,
		S_STAT    = 9'b100000000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_nxt = S_STAT;
				if (sts.bad_class) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ST_BAD_CLASS;
				end else begin
					case (sts.op)
						OP_RESERVE: begin
							if (sts.oversize) begin
								cmd.set_st  = 1'b1;
								cmd.st_code = ST_NO_SPACE;
							end else begin
								state_nxt = S_RLOOP;
							end
						end
						OP_PUSH: begin
							if (sts.push_full) begin
								cmd.set_st  = 1'b1;
								cmd.st_code = ST_NO_SPACE;
							end else begin
								cmd.push = 1'b1;
							end
						end
						OP_PLAN: begin
							cmd.plan_init = 1'b1;
							state_nxt     = S_PCLASS;
						end
						OP_RETIRE: begin
							if (sts.retire_over) begin
								cmd.set_st  = 1'b1;
								cmd.st_code = ST_RETIRE_OVER;
							end else begin
								cmd.retire = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_RLOOP: begin
				if (sts.drop_needed) begin
					cmd.rd_first = 1'b1;
					state_nxt    = S_RFIRST;
				end else begin
					state_nxt = S_STAT;
				end
			end
			S_RFIRST: begin
				if (sts.out_free) begin
					cmd.emit_handle = 1'b1;
					if (sts.first_grp && sts.two_held) begin
						cmd.rd_second = 1'b1;
						state_nxt     = S_RSECOND;
					end else begin
						cmd.adv_one = 1'b1;
						state_nxt   = S_RLOOP;
					end
				end
			end
			S_RSECOND: begin
				if (!sts.second_last) begin
					cmd.adv_one = 1'b1;
					state_nxt   = S_RLOOP;
				end else if (sts.out_free) begin
					cmd.emit_handle = 1'b1;
					cmd.adv_two     = 1'b1;
					state_nxt       = S_RLOOP;
				end
			end
			S_PCLASS: begin
				if (sts.plan_more) begin
					cmd.plan_start = 1'b1;
					state_nxt      = S_PREAD;
				end else begin
					state_nxt = S_STAT;
				end
			end
			S_PREAD: begin
				if (sts.plan_pending) begin
					cmd.plan_rd = 1'b1;
					state_nxt   = S_PEMIT;
				end else begin
					cmd.plan_next = 1'b1;
					state_nxt     = S_PCLASS;
				end
			end
			S_PEMIT: begin
				if (sts.out_free) begin
					cmd.emit_handle = 1'b1;
					cmd.plan_sel    = 1'b1;
					cmd.plan_step   = 1'b1;
					state_nxt       = S_PREAD;
				end
			end
			S_STAT: begin
				if (sts.out_free) begin
					cmd.emit_status = 1'b1;
					state_nxt       = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end
endmodule

/* rtl/tcq_datapath.sv */
module tcq_datapath import tcq_pkg::*; #(
	parameter int QUEUE_DEPTH  = 256,
	parameter int MAX_BATCH    = 32,
	parameter int HANDLE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [8:0]              cfg_data,
	input  logic [1:0]              opcode,
	input  logic [1:0]              traffic_class,
	input  logic [HANDLE_WIDTH-1:0] packet_handle,
	input  logic                    starts_group,
	input  logic                    ends_group,
	input  logic [5:0]              entry_count,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [1:0]              result_kind,
	output logic [1:0]              result_class,
	output logic [HANDLE_WIDTH-1:0] result_handle,
	output logic [1:0]              status_code,
	output logic [5:0]              realtime_planned,
	output logic [5:0]              video_planned,
	output logic [5:0]              data_planned,
	output logic                    last_result
);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW = (OW > 10) ? OW : 10;
	localparam int AW = $clog2(3 * QUEUE_DEPTH);
	localparam int EW = HANDLE_WIDTH + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [6:0]    MAXB_C  = 7'(MAX_BATCH);

	function automatic logic [PW-1:0] wrap(input logic [PW-1:0] h, input logic [OW-1:0] off);
		logic [OW:0] s;
		s = (OW+1)'(h) + (OW+1)'(off);
		if (s >= (OW+1)'(QUEUE_DEPTH)) begin
			s = s - (OW+1)'(QUEUE_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	function automatic logic [AW-1:0] base(input logic [1:0] c);
		logic [AW-1:0] b;
		case (c)
			2'd1:    b = AW'(QUEUE_DEPTH);
			2'd2:    b = AW'(2 * QUEUE_DEPTH);
			default: b = '0;
		endcase
		return b;
	endfunction

	op_t                     op_q;
	logic [1:0]              cls_q;
	logic [5:0]              cnt_q;
	logic [HANDLE_WIDTH-1:0] hnd_q;
	logic                    sg_q, eg_q;
	logic [1:0]              st_q;
	logic [PW-1:0]           head_q [3];
	logic [OW-1:0]           occ_q [3];
	logic [5:0]              bcap_q;
	logic [8:0]              qlim_q;
	logic [1:0]              pc_q;
	logic [5:0]              rem_q, take_q, pi_q;
	logic [5:0]              planned_q [3];

	logic [AW-1:0] ram_addr;
	logic [EW-1:0] ram_rdata;
	logic          ram_re;

	logic          bad;
	logic [1:0]    csel, psel;
	logic [5:0]    cap_e;
	logic [CW-1:0] lim_e, occ_c, occ_p, cnt_c;
	logic          out_free;

	assign bad   = (cls_q == CLASS_INVALID);
	assign csel  = bad ? 2'd0 : cls_q;
	assign psel  = (pc_q == CLASS_INVALID) ? 2'd0 : pc_q;
	assign cap_e = (7'(bcap_q) > MAXB_C) ? MAXB_C[5:0] : bcap_q;
	assign lim_e = (CW'(qlim_q) > DEPTH_C) ? DEPTH_C : CW'(qlim_q);
	assign occ_c = CW'(occ_q[csel]);
	assign occ_p = CW'(occ_q[psel]);
	assign cnt_c = CW'(cnt_q);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		sts.op           = op_q;
		sts.bad_class    = bad;
		sts.oversize     = (cnt_c > lim_e) || (cnt_q > cap_e) || (occ_c > lim_e);
		sts.push_full    = (occ_c >= lim_e);
		sts.retire_over  = (cnt_c > occ_c);
		sts.drop_needed  = (occ_c != '0) && ((lim_e - occ_c) < cnt_c);
		sts.first_grp    = ram_rdata[HANDLE_WIDTH];
		sts.two_held     = (occ_c >= CW'(2));
		sts.second_last  = ram_rdata[HANDLE_WIDTH+1];
		sts.plan_more    = (pc_q <= cls_q) && (rem_q != '0);
		sts.plan_pending = (pi_q < take_q);
		sts.out_free     = out_free;
	end

	// One port serves both the push write and every walk read.
	always_comb begin
		if (cmd.plan_rd) begin
			ram_addr = base(psel) + AW'(wrap(head_q[psel], OW'(pi_q)));
		end else if (cmd.rd_second) begin
			ram_addr = base(csel) + AW'(wrap(head_q[csel], OW'(1)));
		end else if (cmd.rd_first) begin
			ram_addr = base(csel) + AW'(head_q[csel]);
		end else begin
			ram_addr = base(csel) + AW'(wrap(head_q[csel], occ_q[csel]));
		end
	end
	assign ram_re = cmd.rd_first || cmd.rd_second || cmd.plan_rd;

	tcq_ram #(.WIDTH(EW), .DEPTH(3 * QUEUE_DEPTH)) u_store (
		.clk   (clk),
		.we    (cmd.push),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata ({eg_q, sg_q, hnd_q}),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcap_q    <= BATCH_CAPACITY_RESET;
			qlim_q    <= QUEUE_LIMIT_RESET;
			st_q      <= ST_OK;
			pc_q      <= '0;
			rem_q     <= '0;
			take_q    <= '0;
			pi_q      <= '0;
			out_valid <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				head_q[c]    <= '0;
				occ_q[c]     <= '0;
				planned_q[c] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BATCH_CAPACITY: bcap_q <= cfg_data[5:0];
					CFG_QUEUE_LIMIT:    qlim_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.latch) begin
				st_q <= ST_OK;
				for (int c = 0; c < 3; c++) begin
					planned_q[c] <= '0;
				end
			end
			if (cmd.set_st) begin
				st_q <= cmd.st_code;
			end
			if (cmd.push) begin
				occ_q[csel] <= occ_q[csel] + OW'(1);
			end
			if (cmd.retire) begin
				head_q[csel] <= wrap(head_q[csel], OW'(cnt_q));
				occ_q[csel]  <= occ_q[csel] - OW'(cnt_q);
			end
			if (cmd.adv_one || cmd.adv_two) begin
				head_q[csel] <= wrap(head_q[csel], cmd.adv_two ? OW'(2) : OW'(1));
				occ_q[csel]  <= occ_q[csel] - (cmd.adv_two ? OW'(2) : OW'(1));
			end
			if (cmd.plan_init) begin
				pc_q  <= '0;
				rem_q <= cap_e;
			end
			if (cmd.plan_start) begin
				take_q <= (occ_p < CW'(rem_q)) ? occ_p[5:0] : rem_q;
				pi_q   <= '0;
			end
			if (cmd.plan_step) begin
				pi_q            <= pi_q + 6'd1;
				planned_q[psel] <= planned_q[psel] + 6'd1;
			end
			if (cmd.plan_next) begin
				rem_q <= rem_q - take_q;
				pc_q  <= pc_q + 2'd1;
			end
			if (cmd.emit_handle || cmd.emit_status) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= op_t'(opcode);
			cls_q <= traffic_class;
			cnt_q <= entry_count;
			hnd_q <= packet_handle;
			sg_q  <= starts_group;
			eg_q  <= ends_group;
		end
		if (cmd.emit_status) begin
			result_kind      <= KIND_STATUS;
			result_class     <= csel;
			result_handle    <= '0;
			status_code      <= st_q;
			realtime_planned <= planned_q[0];
			video_planned    <= planned_q[1];
			data_planned     <= planned_q[2];
			last_result      <= 1'b1;
		end else if (cmd.emit_handle) begin
			result_kind      <= cmd.plan_sel ? KIND_PLAN : KIND_DROP;
			result_class     <= cmd.plan_sel ? psel : csel;
			result_handle    <= ram_rdata[HANDLE_WIDTH-1:0];
			status_code      <= ST_OK;
			realtime_planned <= '0;
			video_planned    <= '0;
			data_planned     <= '0;
			last_result      <= 1'b0;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(occ_q[0]) <= DEPTH_C) && (CW'(occ_q[1]) <= DEPTH_C) && (CW'(occ_q[2]) <= DEPTH_C))
		else $error("class occupancy beyond queue depth");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_handle || cmd.emit_status) |-> out_free)
		else $error("result loaded while output register is held");

	// Each planned handle must still fit in the batch budget of the running plan.
	a_plan_budget: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.plan_step |->
		((8'(planned_q[0]) + 8'(planned_q[1]) + 8'(planned_q[2])) < 8'(cap_e)))
		else $error("plan exceeded batch budget");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> (CW'(occ_q[$past(csel)]) <= $past(lim_e)))
		else $error("push went past the queue limit");
endmodule

/* rtl/three_class_drop_oldest_tx_queues.sv */
// Channel  Direction  Fields
// req      sink       opcode, traffic_class, packet_handle, starts_group, ends_group,
//                     entry_count
// rsp      source     result_kind, result_class, result_handle, status_code,
//                     realtime_planned, video_planned, data_planned, last_result
// cfg      write      cfg_we, cfg_index (0 batch_capacity, 1 queue_limit), cfg_data
//
// One item is worked on at a time. A push, retire or refused item returns only a status.
// An accepted reserve drops from the head while room is short: a single entry, or a
// pair when a group start is followed by the entry that ends the group.
// A plan visits the classes in order and emits each planned handle, then the status.
// The single-port descriptor store is read for each walked entry.
// Reset clears all queues at once; the store needs no clearing pass.
// A stalled result holds the walk; the next item is taken while the final status waits.
module three_class_drop_oldest_tx_queues import tcq_pkg::*; #(
	parameter int QUEUE_DEPTH  = 256,
	parameter int MAX_BATCH    = 32,
	parameter int HANDLE_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	tcq_req_if.sink    req,
	tcq_rsp_if.source  rsp
);
	// The controller sequences each item; the datapath holds the queue state,
	// the shared descriptor store and the output register.
	cmd_t cmd;
	sts_t sts;

	tcq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcq_datapath #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.MAX_BATCH    (MAX_BATCH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.opcode           (req.opcode),
		.traffic_class    (req.traffic_class),
		.packet_handle    (req.packet_handle),
		.starts_group     (req.starts_group),
		.ends_group       (req.ends_group),
		.entry_count      (req.entry_count),
		.cmd              (cmd),
		.sts              (sts),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.result_kind      (rsp.result_kind),
		.result_class     (rsp.result_class),
		.result_handle    (rsp.result_handle),
		.status_code      (rsp.status_code),
		.realtime_planned (rsp.realtime_planned),
		.video_planned    (rsp.video_planned),
		.data_planned     (rsp.data_planned),
		.last_result      (rsp.last_result)
	);
endmodule
